// ===== hw/rtl/mbd_pkg.sv =====
package mbd_pkg;

    // Field widths fixed by the pixel format and the register map.
    localparam int CHAN_W     = 8;
    localparam int SUM_W      = CHAN_W + 1;
    localparam int N_LANES    = 4;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHANNELS = 2'd2;

    // Per-lane controls for the horizontal pair stage and the average stage.
    typedef struct packed {
        logic restart;
        logic hold_we;
        logic s1_we;
        logic w_one;
        logic h_one;
    } lane_ctl_t;

    // What the merging stage is told about the item leaving the lanes.
    typedef struct packed {
        logic valid;
        logic done;
    } res_ctl_t;

endpackage

// ===== hw/rtl/mbd_ram.sv =====
module mbd_ram #(
    parameter int WIDTH  = 36,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/mbd_lane.sv =====
module mbd_lane
    import mbd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  lane_ctl_t         ctl,
    input  logic [CHAN_W-1:0] pix,
    input  logic [SUM_W-1:0]  row_sum,
    output logic [SUM_W-1:0]  pair_sum,
    output logic [CHAN_W-1:0] avg
);

    logic [CHAN_W-1:0] hold_reg;
    logic [SUM_W-1:0]  hs_reg;
    logic [SUM_W:0]    vsum;

    // Horizontal pair: a one-pixel-wide level uses the pixel twice.
    assign pair_sum = ctl.w_one ? {pix, 1'b0}
                                : SUM_W'({1'b0, hold_reg} + {1'b0, pix});

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.restart) begin
            hold_reg <= '0;
        end else if (ctl.hold_we) begin
            hold_reg <= pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.s1_we) begin
            hs_reg <= pair_sum;
        end
    end

    // Vertical pair: a one-row level doubles the pair instead of reading the store.
    assign vsum = {1'b0, row_sum} + {1'b0, hs_reg};
    assign avg  = ctl.h_one ? hs_reg[SUM_W-1:1] : vsum[SUM_W:2];

endmodule

// ===== hw/rtl/mbd_merge.sv =====
module mbd_merge
    import mbd_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  res_ctl_t                  res,
    input  logic                      four,
    input  logic [N_LANES*CHAN_W-1:0] avg,
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic [N_LANES*CHAN_W-1:0] m_tdata,
    output logic                      m_tlast,
    output logic                      out_free
);

    logic                      valid_reg;
    logic [N_LANES*CHAN_W-1:0] data_reg;
    logic                      last_reg;
    logic [N_LANES*CHAN_W-1:0] data_next;

    assign out_free = !valid_reg || m_tready;

    // Gather the lanes; the fourth channel reads zero in three-channel mode.
    always_comb begin
        data_next = avg;
        if (!four) begin
            data_next[N_LANES*CHAN_W-1 -: CHAN_W] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res.valid) begin
            data_reg <= data_next;
            last_reg <= res.done;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== hw/rtl/mipmap_box_downsample_core.sv =====
// 2x2 box-filter mip reduction, one source pixel accepted per clock when the output drains.
// A block's last pixel puts its pair sum and line store read in the stage register, then in
// the output register driving m_tvalid once that is free. Throughput: one pixel per cycle
// while the output drains, set by the single read and single write of the line store.
// Reset (aresetn, synchronous, active low): 1x1 level, four channels, counters at zero,
// no beats in flight. The line store is not cleared; each entry is written before use.
module mipmap_box_downsample_core
    import mbd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Source pixel stream.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [N_LANES*CHAN_W-1:0] s_tdata,   // chan_a, chan_b, chan_c, chan_d
    // Reduced pixel stream.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [N_LANES*CHAN_W-1:0] m_tdata,   // avg_a, avg_b, avg_c, avg_d
    output logic                      m_tlast,   // level_done
    // Register writes.
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    // Sizes of the counters and the line store follow from the largest level.
    localparam int SW      = $clog2(MAX_WIDTH + 1);
    localparam int SH      = $clog2(MAX_HEIGHT + 1);
    localparam int CNT_W   = $clog2(MAX_WIDTH);
    localparam int RNT_W   = $clog2(MAX_HEIGHT);
    localparam int DEPTH   = MAX_WIDTH / 2;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OY_D    = MAX_HEIGHT / 2;
    localparam int OY_W    = (OY_D > 1) ? $clog2(OY_D) : 1;
    localparam int STORE_W = N_LANES * SUM_W;

    // Configuration, held as clamped level sizes.
    logic [SW-1:0]    w_reg, w_next;
    logic [SH-1:0]    h_reg, h_next;
    logic             four_reg, four_next;
    logic             restart;

    // Raster position of the next source pixel.
    logic [CNT_W-1:0] col_cnt_reg, col_cnt_next;
    logic [RNT_W-1:0] row_cnt_reg, row_cnt_next;

    // Pipeline stage between the pair stage and the average stage.
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_emit_reg;
    logic             s1_done_reg;

    logic             accept;
    logic             s1_adv;
    logic             out_free;

    logic             w_one, h_one;
    logic [CNT_W-1:0] w_m1;
    logic [RNT_W-1:0] h_m1;
    logic [IDX_W-1:0] dw_m1;
    logic [OY_W-1:0]  dh_m1;
    logic             col_in, row_in;
    logic             have_pair;
    logic             emit0;
    logic             done0;
    logic [IDX_W-1:0] idx;
    logic [OY_W-1:0]  oy;
    logic             store_we;

    logic [CHAN_W-1:0]         pix [N_LANES];
    logic [SUM_W-1:0]          hs  [N_LANES];
    logic [STORE_W-1:0]        store_wdata;
    logic [STORE_W-1:0]        store_rdata;
    logic [N_LANES*CHAN_W-1:0] avg_bus;
    lane_ctl_t                 lane_ctl;
    res_ctl_t                  res_ctl;

    // A size of zero means one, and sizes beyond the build limit saturate to it.
    function automatic logic [SW-1:0] clamp_w(input logic [CFG_DATA_W-1:0] v);
        if (v == '0) begin
            return SW'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            return SW'(MAX_WIDTH);
        end
        return SW'(v);
    endfunction

    function automatic logic [SH-1:0] clamp_h(input logic [CFG_DATA_W-1:0] v);
        if (v == '0) begin
            return SH'(1);
        end else if (32'(v) > MAX_HEIGHT) begin
            return SH'(MAX_HEIGHT);
        end
        return SH'(v);
    endfunction

    // The configuration channel never stalls. Any write to a known register
    // restarts the level; writes beyond the register list are dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        w_next    = w_reg;
        h_next    = h_reg;
        four_next = four_reg;
        restart   = 1'b0;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IDX_WIDTH: begin
                    w_next  = clamp_w(cfg_data);
                    restart = 1'b1;
                end
                CFG_IDX_HEIGHT: begin
                    h_next  = clamp_h(cfg_data);
                    restart = 1'b1;
                end
                CFG_IDX_CHANNELS: begin
                    four_next = cfg_data[0];
                    restart   = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg    <= SW'(1);
            h_reg    <= SH'(1);
            four_reg <= 1'b1;
        end else begin
            w_reg    <= w_next;
            h_reg    <= h_next;
            four_reg <= four_next;
        end
    end

    // Quantities of the level that follow from its size. For sizes of two or
    // more, the kept columns are those below the even part of the width.
    assign w_one = (w_reg == SW'(1));
    assign h_one = (h_reg == SH'(1));
    assign w_m1  = CNT_W'(w_reg - SW'(1));
    assign h_m1  = RNT_W'(h_reg - SH'(1));
    assign dw_m1 = w_one ? '0 : IDX_W'((w_reg >> 1) - SW'(1));
    assign dh_m1 = h_one ? '0 : OY_W'((h_reg >> 1) - SH'(1));

    assign col_in = SW'(col_cnt_reg) < {w_reg[SW-1:1], 1'b0};
    assign row_in = SH'(row_cnt_reg) < {h_reg[SH-1:1], 1'b0};

    // A pair closes on every pixel of a one-wide level, otherwise on each odd column kept.
    assign have_pair = w_one || (col_in && col_cnt_reg[0]);
    assign idx       = w_one ? '0 : IDX_W'(col_cnt_reg >> 1);
    assign oy        = h_one ? '0 : OY_W'(row_cnt_reg >> 1);

    // Even rows park pair sums in the line store; odd rows, or all of a one-row level, end blocks.
    assign store_we = accept && have_pair && !h_one && row_in && !row_cnt_reg[0];
    assign emit0    = have_pair && (h_one || (row_in && row_cnt_reg[0]));
    assign done0    = (idx == dw_m1) && (oy == dh_m1);

    // Handshake. The stage register moves on when its item needs no output
    // slot or the output register is free, so a pixel is taken each cycle
    // while the result side keeps draining.
    assign s1_adv   = !s1_emit_reg || out_free;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (restart) begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end else if (accept) begin
            if (col_cnt_reg == w_m1) begin
                col_cnt_next = '0;
                row_cnt_next = (row_cnt_reg == h_m1) ? '0 : RNT_W'(row_cnt_reg + 1'b1);
            end else begin
                col_cnt_next = CNT_W'(col_cnt_reg + 1'b1);
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end else begin
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
            s1_valid_reg <= s1_valid_next;
            if (accept) begin
                s1_emit_reg <= emit0;
            end else if (s1_adv) begin
                s1_emit_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_done_reg <= done0;
        end
    end

    // One lane per channel; the fourth reads zero in three-channel mode.
    assign pix[0] = s_tdata[0*CHAN_W +: CHAN_W];
    assign pix[1] = s_tdata[1*CHAN_W +: CHAN_W];
    assign pix[2] = s_tdata[2*CHAN_W +: CHAN_W];
    assign pix[3] = four_reg ? s_tdata[3*CHAN_W +: CHAN_W] : '0;

    assign lane_ctl.restart = restart;
    assign lane_ctl.hold_we = accept && !w_one && col_in && !col_cnt_reg[0];
    assign lane_ctl.s1_we   = accept;
    assign lane_ctl.w_one   = w_one;
    assign lane_ctl.h_one   = h_one;

    for (genvar i = 0; i < N_LANES; i++) begin : g_lane
        mbd_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (lane_ctl),
            .pix      (pix[i]),
            .row_sum  (store_rdata[i*SUM_W +: SUM_W]),
            .pair_sum (hs[i]),
            .avg      (avg_bus[i*CHAN_W +: CHAN_W])
        );
        assign store_wdata[i*SUM_W +: SUM_W] = hs[i];
    end

    // Line store of horizontal pair sums, one entry per output column. It is
    // read on every accepted pixel so the data lines up with the stage register.
    mbd_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store_we),
        .wr_addr (idx),
        .wr_data (store_wdata),
        .rd_en   (accept),
        .rd_addr (idx),
        .rd_data (store_rdata)
    );

    assign res_ctl.valid = s1_valid_reg && s1_emit_reg;
    assign res_ctl.done  = s1_done_reg;

    mbd_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res_ctl),
        .four     (four_reg),
        .avg      (avg_bus),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .out_free (out_free)
    );

`ifndef SYNTHESIS
    // The raster position never runs past the level.
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_cnt_reg <= w_m1) && (row_cnt_reg <= h_m1))
        else $error("raster position beyond the level");

    // An empty output register never holds back the source side.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("source stalled with an empty output register");

    // Every accepted pixel occupies the stage register in the next cycle.
    a_stage_load: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted pixel lost before the average stage");

    // A pixel that closes a block under a full output is held, not dropped.
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_emit_reg && !out_free) |=> (s1_valid_reg && s1_emit_reg))
        else $error("finished block dropped while the output was stalled");
`endif

endmodule
